>>> hw/rtl/vil_pkg.sv
// Shared constants, tables and types for the vertically integrated liquid block.
package vil_pkg;

	localparam int LUT_ADDR_BITS = 10;
	localparam int KW = $clog2(LUT_ADDR_BITS + 1);

	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [32:0] LOG2Z_PER_DBZ = 33'd89172328;
	localparam logic [32:0] RAD_PER_CENTIDEG = 33'd191900980;
	localparam logic signed [31:0] LOG2_COEF = -32'sd1189423;
	localparam logic [13:0] EL_MAX = 14'd9000;

	localparam logic [32:0] RECIP_D110 = 33'(((65'd1 << 39) + 65'd109) / 65'd110);
	localparam logic [32:0] RECIP_D72 = 33'(((65'd1 << 39) + 65'd71) / 65'd72);
	localparam logic [32:0] RECIP_D42 = 33'(((65'd1 << 38) + 65'd41) / 65'd42);
	localparam logic [32:0] RECIP_D20 = 33'(((65'd1 << 37) + 65'd19) / 65'd20);
	localparam logic [32:0] RECIP_D6 = 33'(((65'd1 << 35) + 65'd5) / 65'd6);
	localparam logic [32:0] RECIP_D7 = 33'(((34'd1 << 27) + 34'd6) / 34'd7);

	localparam logic [30:0] ROOT_TAB [14] = '{
		31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280439, 31'd1097253708,
		31'd1085434106, 31'd1079572136, 31'd1076653033, 31'd1075196443, 31'd1074468888,
		31'd1074105294, 31'd1073923544, 31'd1073832680, 31'd1073787251
	};

	localparam logic CFG_INNER = 1'b0;
	localparam logic CFG_GSIZE = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_LZ, S_X, S_X2, S_X2CAP, S_TMUL, S_TDIV, S_TUPD, S_SIN, S_DIST,
		S_H, S_HGT, S_PSET, S_PSTEP, S_PACC, S_PSHIFT, S_LINIT, S_LSQ, S_LUPD,
		S_DIV7, S_LOGM, S_MLO, S_MHI, S_SUM, S_DONE
	} state_t;

	function automatic logic [32:0] sine_recip(input logic [2:0] i);
		case (i)
			3'd0: return RECIP_D110;
			3'd1: return RECIP_D72;
			3'd2: return RECIP_D42;
			3'd3: return RECIP_D20;
			3'd4: return RECIP_D6;
			default: return RECIP_D6;
		endcase
	endfunction

	function automatic logic [5:0] sine_shift(input logic [2:0] i);
		case (i)
			3'd0: return 6'd39;
			3'd1: return 6'd39;
			3'd2: return 6'd38;
			3'd3: return 6'd37;
			3'd4: return 6'd35;
			default: return 6'd35;
		endcase
	endfunction

	function automatic logic [32:0] root_coef(input logic [KW-1:0] k);
		return {2'b00, ROOT_TAB[k]};
	endfunction

endpackage

>>> hw/rtl/vil_mul.sv
// Shared unsigned multiplier with registered product.
module vil_mul (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic [65:0] prod
);

	logic [65:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 66'(a) * 66'(b);
	end

	assign prod = prod_q;

endmodule

>>> hw/rtl/vertically_integrated_liquid.sv
// Vertically integrated liquid of one range-gate column, top level.
//
// Items arrive on item_valid/item_ready, one sweep per item from the lowest
// sweep up. first_sweep starts a new column, last_sweep ends it and makes one
// result on result_valid/result_ready carrying the saturated column sum (vil)
// and the gate of that item. Items without last_sweep make no result.
// Registers inner_distance and gate_size are written through write_en,
// write_index and write_data; write them only while the block is idle,
// which the block does not enforce. Every product goes through a single
// registered multiplier in turn, so an item's processing time follows the
// number of multiply passes (sine series, one pass per set bit of the 2^x
// fraction, log2 squarings when both layer ends are positive). item_ready is
// high only between items. A finished result waits in the output register;
// the next item is taken meanwhile, and a column end waits in its last cycle
// until the previous result has been taken. Reset clears the column state and
// the registers go to inner_distance 0 and gate_size 1.0.
module vertically_integrated_liquid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               write_en,
	input  logic               write_index,
	input  logic [15:0]        write_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic signed [11:0] dbz,
	input  logic [13:0]        elevation,
	input  logic [11:0]        gate,
	input  logic               first_sweep,
	input  logic               last_sweep,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [31:0]        vil,
	output logic [11:0]        gate_out
);

	localparam int L = vil_pkg::LUT_ADDR_BITS;

	vil_pkg::state_t state_q, state_d;

	logic [11:0] inner_q;
	logic [15:0] gsize_q;

	logic signed [11:0] dbz_q;
	logic [13:0] el_q;
	logic [11:0] gate_q;
	logic first_q, last_q, pos_q;

	logic signed [31:0] lz_q, prev_lz_q, hi_q, log_avg_q, e_q;
	logic [31:0] x_q, x2_q, t_q, sin_q, h_q, prev_h_q, dz_q, sum_q;
	logic prev_pos_q;
	logic [2:0] idx_q;

	logic pow_layer_q, pz_q, left_q, neg_q;
	logic [6:0] sh_q;
	logic [L-1:0] f_q, frac_q;
	logic [31:0] m_q, y_q;
	logic [vil_pkg::KW-1:0] k_q;
	logic [63:0] pow_q, plo_q;

	logic [31:0] vil_q;
	logic [11:0] gate_out_q;
	logic rvalid_q;

	logic [32:0] op_a, op_b;
	logic [65:0] prod;

	vil_mul u_mul (.clk(clk), .a(op_a), .b(op_b), .prod(prod));

	// derived values
	logic [31:0] p30;
	logic [47:0] lzsum;
	logic [31:0] h_new, dz_new, tq;
	logic signed [33:0] pv, v4, mag;
	logic [23:0] vc;
	logic signed [9:0] ipm;
	logic [L-1:0] frac_n;
	logic [31:0] yy, s_sum, q7;
	logic signed [31:0] lz_new, qs, log_l;
	logic [62:0] s_hi;
	logic [31:0] layer, sum_add;
	logic [32:0] sum_wide;
	logic acc_ok;

	assign p30 = prod[61:30];
	assign lzsum = prod[47:0] + 48'd32768;
	assign lz_new = pos_q ? $signed(lzsum[47:16]) : 32'sd0;
	assign h_new = p30;
	assign dz_new = first_q ? h_new : ((h_new >= prev_h_q) ? h_new - prev_h_q : prev_h_q - h_new);
	assign tq = 32'(prod >> vil_pkg::sine_shift(idx_q));

	assign pv = $signed({{2{e_q[31]}}, e_q}) + 34'sd8388608;
	assign vc = (pv > 34'sd16384000) ? 24'd16384000 : pv[23:0];
	assign ipm = $signed({2'b00, vc[23:16]}) - 10'sd128 + (pow_layer_q ? 10'sd2 : 10'sd0);

	assign yy = p30;
	assign frac_n = {frac_q[L-2:0], yy[31]};
	assign log_l = hi_q + $signed(32'(frac_n) << (16 - L)) - 32'sd65536;
	assign s_sum = vil_pkg::Q30_ONE + pow_q[31:0];

	assign v4 = $signed({log_avg_q, 2'b00});
	assign mag = v4[33] ? -v4 : v4;
	assign q7 = prod[58:27];
	assign qs = neg_q ? -$signed(q7) : $signed(q7);

	assign s_hi = prod[62:0] + 63'(plo_q[63:32]);
	assign layer = (s_hi >= 63'd16777216) ? 32'hFFFF_FFFF : {s_hi[23:0], plo_q[31:24]};
	assign sum_wide = 33'(sum_q) + 33'(layer);
	assign sum_add = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

	assign acc_ok = !(last_q && rvalid_q && !result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vil_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_a = '0;
		op_b = '0;
		item_ready = 1'b0;
		case (state_q)
			vil_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) state_d = vil_pkg::S_LZ;
			end
			vil_pkg::S_LZ: begin
				op_a = pos_q ? 33'(dbz_q[10:0]) : 33'd0;
				op_b = vil_pkg::LOG2Z_PER_DBZ;
				state_d = vil_pkg::S_X;
			end
			vil_pkg::S_X: begin
				op_a = 33'(el_q);
				op_b = vil_pkg::RAD_PER_CENTIDEG;
				state_d = vil_pkg::S_X2;
			end
			vil_pkg::S_X2: begin
				op_a = 33'(prod[41:10]);
				op_b = 33'(prod[41:10]);
				state_d = vil_pkg::S_X2CAP;
			end
			vil_pkg::S_X2CAP: state_d = vil_pkg::S_TMUL;
			vil_pkg::S_TMUL: begin
				op_a = 33'(x2_q);
				op_b = 33'(t_q);
				state_d = vil_pkg::S_TDIV;
			end
			vil_pkg::S_TDIV: begin
				op_a = 33'(p30);
				op_b = vil_pkg::sine_recip(idx_q);
				state_d = vil_pkg::S_TUPD;
			end
			vil_pkg::S_TUPD: state_d = (idx_q == 3'd4) ? vil_pkg::S_SIN : vil_pkg::S_TMUL;
			vil_pkg::S_SIN: begin
				op_a = 33'(x_q);
				op_b = 33'(t_q);
				state_d = vil_pkg::S_DIST;
			end
			vil_pkg::S_DIST: begin
				op_a = 33'({1'b0, inner_q} + {1'b0, gate_q});
				op_b = 33'(gsize_q);
				state_d = vil_pkg::S_H;
			end
			vil_pkg::S_H: begin
				op_a = prod[32:0];
				op_b = 33'(sin_q);
				state_d = vil_pkg::S_HGT;
			end
			vil_pkg::S_HGT: begin
				if (first_q) begin
					state_d = pos_q ? vil_pkg::S_DIV7 : vil_pkg::S_DONE;
				end else if (pos_q && prev_pos_q) begin
					state_d = vil_pkg::S_PSET;
				end else if (pos_q || prev_pos_q) begin
					state_d = vil_pkg::S_DIV7;
				end else begin
					state_d = vil_pkg::S_DONE;
				end
			end
			vil_pkg::S_PSET: state_d = vil_pkg::S_PSTEP;
			vil_pkg::S_PSTEP: begin
				if (k_q == vil_pkg::KW'(L)) begin
					state_d = vil_pkg::S_PSHIFT;
				end else if (f_q[L-1]) begin
					op_a = 33'(m_q);
					op_b = vil_pkg::root_coef(k_q);
					state_d = vil_pkg::S_PACC;
				end
			end
			vil_pkg::S_PACC: state_d = vil_pkg::S_PSTEP;
			vil_pkg::S_PSHIFT: state_d = pow_layer_q ? vil_pkg::S_MLO : vil_pkg::S_LINIT;
			vil_pkg::S_LINIT: state_d = s_sum[31] ? vil_pkg::S_DIV7 : vil_pkg::S_LSQ;
			vil_pkg::S_LSQ: begin
				op_a = 33'(y_q);
				op_b = 33'(y_q);
				state_d = vil_pkg::S_LUPD;
			end
			vil_pkg::S_LUPD: begin
				state_d = (k_q == vil_pkg::KW'(L - 1)) ? vil_pkg::S_DIV7 : vil_pkg::S_LSQ;
			end
			vil_pkg::S_DIV7: begin
				op_a = mag[32:0];
				op_b = vil_pkg::RECIP_D7;
				state_d = vil_pkg::S_LOGM;
			end
			vil_pkg::S_LOGM: state_d = vil_pkg::S_PSET;
			vil_pkg::S_MLO: begin
				op_a = 33'(pow_q[31:0]);
				op_b = 33'(dz_q);
				state_d = vil_pkg::S_MHI;
			end
			vil_pkg::S_MHI: begin
				op_a = 33'(pow_q[63:32]);
				op_b = 33'(dz_q);
				state_d = vil_pkg::S_SUM;
			end
			vil_pkg::S_SUM: state_d = vil_pkg::S_DONE;
			vil_pkg::S_DONE: if (acc_ok) state_d = vil_pkg::S_IDLE;
			default: state_d = vil_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			gsize_q <= 16'd256;
		end else if (write_en) begin
			case (write_index)
				vil_pkg::CFG_INNER: inner_q <= write_data[11:0];
				vil_pkg::CFG_GSIZE: gsize_q <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_lz_q <= '0;
			prev_pos_q <= 1'b0;
			prev_h_q <= '0;
			sum_q <= '0;
			rvalid_q <= 1'b0;
			idx_q <= '0;
			k_q <= '0;
		end else begin
			rvalid_q <= (rvalid_q && !result_ready) ||
				(state_q == vil_pkg::S_DONE && acc_ok && last_q);
			case (state_q)
				vil_pkg::S_X2: idx_q <= '0;
				vil_pkg::S_TUPD: if (idx_q != 3'd4) idx_q <= idx_q + 3'd1;
				vil_pkg::S_PSET: k_q <= '0;
				vil_pkg::S_PSTEP: if (k_q != vil_pkg::KW'(L) && !f_q[L-1]) k_q <= k_q + 1'b1;
				vil_pkg::S_PACC: k_q <= k_q + 1'b1;
				vil_pkg::S_LINIT: k_q <= '0;
				vil_pkg::S_LUPD: k_q <= k_q + 1'b1;
				vil_pkg::S_HGT: if (first_q && !pos_q) sum_q <= '0;
				vil_pkg::S_SUM: sum_q <= first_q ? layer : sum_add;
				vil_pkg::S_DONE: begin
					if (acc_ok) begin
						prev_lz_q <= lz_q;
						prev_pos_q <= pos_q;
						prev_h_q <= h_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			vil_pkg::S_IDLE: begin
				dbz_q <= dbz;
				el_q <= (elevation > vil_pkg::EL_MAX) ? vil_pkg::EL_MAX : elevation;
				gate_q <= gate;
				first_q <= first_sweep;
				last_q <= last_sweep;
				pos_q <= !dbz[11] && (dbz != 12'sd0);
			end
			vil_pkg::S_X: lz_q <= lz_new;
			vil_pkg::S_X2: x_q <= prod[41:10];
			vil_pkg::S_X2CAP: begin
				x2_q <= p30;
				t_q <= vil_pkg::Q30_ONE;
			end
			vil_pkg::S_TUPD: t_q <= vil_pkg::Q30_ONE - tq;
			vil_pkg::S_DIST: sin_q <= p30;
			vil_pkg::S_HGT: begin
				h_q <= h_new;
				dz_q <= dz_new;
				pow_layer_q <= 1'b0;
				hi_q <= (lz_q > prev_lz_q) ? lz_q : prev_lz_q;
				e_q <= (lz_q > prev_lz_q) ? prev_lz_q - lz_q : lz_q - prev_lz_q;
				if (first_q) log_avg_q <= lz_q;
				else log_avg_q <= (pos_q ? lz_q : prev_lz_q) - 32'sd65536;
			end
			vil_pkg::S_PSET: begin
				f_q <= vc[15 -: L];
				m_q <= vil_pkg::Q30_ONE;
				left_q <= (ipm >= 10'sd0);
				if (ipm >= 10'sd0) sh_q <= (ipm > 10'sd32) ? 7'd32 : 7'(ipm);
				else sh_q <= 7'(-ipm);
				pz_q <= pv[33] || (ipm < -10'sd62);
			end
			vil_pkg::S_PSTEP: if (k_q != vil_pkg::KW'(L) && !f_q[L-1]) f_q <= f_q << 1;
			vil_pkg::S_PACC: begin
				m_q <= p30;
				f_q <= f_q << 1;
			end
			vil_pkg::S_PSHIFT: begin
				if (pz_q) pow_q <= '0;
				else if (left_q) pow_q <= 64'(m_q) << sh_q;
				else pow_q <= 64'(m_q) >> sh_q;
			end
			vil_pkg::S_LINIT: begin
				y_q <= s_sum;
				frac_q <= '0;
				if (s_sum[31]) log_avg_q <= hi_q;
			end
			vil_pkg::S_LUPD: begin
				frac_q <= frac_n;
				y_q <= yy[31] ? (yy >> 1) : yy;
				log_avg_q <= log_l;
			end
			vil_pkg::S_DIV7: neg_q <= v4[33];
			vil_pkg::S_LOGM: begin
				e_q <= vil_pkg::LOG2_COEF + qs;
				pow_layer_q <= 1'b1;
			end
			vil_pkg::S_MHI: plo_q <= prod[63:0];
			vil_pkg::S_DONE: begin
				if (acc_ok && last_q) begin
					vil_q <= sum_q;
					gate_out_q <= gate_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = rvalid_q;
	assign vil = vil_q;
	assign gate_out = gate_out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while busy");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == vil_pkg::S_DONE) && $past(last_q))
		else $error("result without column end");

	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= vil_pkg::KW'(L))
		else $error("fraction step count overrun");

	a_series_index: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'd4)
		else $error("sine series index overrun");

endmodule
